@@ rtl/gshs_pkg.sv @@
// ----------------------------------------------------------------------------
// gshs_pkg
// Types, codes and command tables for the gamepad serial host sequencer.
// ----------------------------------------------------------------------------
package gshs_pkg;

  // Input action codes
  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActInit  = 2'd1;
  localparam logic [1:0] ActPoll  = 2'd2;
  localparam logic [1:0] ActReply = 2'd3;

  // Result kind codes
  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindSend   = 2'd1;
  localparam logic [1:0] KindReport = 2'd2;
  localparam logic [1:0] KindDone   = 2'd3;

  // Script geometry
  localparam int          InitLen       = 32;
  localparam int          PollLen       = 9;
  localparam logic [4:0]  IdPos         = 5'd24;
  localparam logic [4:0]  InitLastPos   = 5'(InitLen - 1);
  localparam logic [4:0]  PollLastPos   = 5'(PollLen - 1);
  localparam logic [4:0]  PollFirstCap  = 5'd3;
  localparam logic [7:0]  AnalogId      = 8'h73;
  localparam logic [15:0] TimeoutReset  = 16'd5000;

  // Command bytes
  localparam logic [7:0] CmdStart   = 8'h01;
  localparam logic [7:0] CmdPoll    = 8'h42;
  localparam logic [7:0] CmdConfig  = 8'h43;
  localparam logic [7:0] CmdAnalog  = 8'h44;
  localparam logic [7:0] CmdLock    = 8'h03;
  localparam logic [7:0] CmdPad     = 8'h5A;
  localparam logic [7:0] CmdZero    = 8'h00;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        frame_first;
    logic        frame_last;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic        init_ok;
  } out_item_t;

  // Init script: enter config, set analog, exit config, poll
  function automatic logic [7:0] init_byte(input logic [4:0] pos);
    logic [7:0] b;
    unique case (pos)
      5'd0, 5'd5, 5'd14, 5'd23: b = CmdStart;
      5'd1, 5'd15:              b = CmdConfig;
      5'd3, 5'd8:               b = CmdStart;
      5'd6:                     b = CmdAnalog;
      5'd9:                     b = CmdLock;
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22: b = CmdPad;
      5'd24:                    b = CmdPoll;
      default:                  b = CmdZero;
    endcase
    return b;
  endfunction

  function automatic logic init_first(input logic [4:0] pos);
    return (pos == 5'd0) || (pos == 5'd5) || (pos == 5'd14) || (pos == 5'd23);
  endfunction

  function automatic logic init_last(input logic [4:0] pos);
    return (pos == 5'd4) || (pos == 5'd13) || (pos == 5'd22) || (pos == 5'd31);
  endfunction

  // Poll frame: 01 42 then zeros
  function automatic logic [7:0] poll_byte(input logic [4:0] pos);
    logic [7:0] b;
    priority if (pos == 5'd0) begin
      b = CmdStart;
    end else if (pos == 5'd1) begin
      b = CmdPoll;
    end else begin
      b = CmdZero;
    end
    return b;
  endfunction

endpackage

@@ rtl/gamepad_serial_host_sequencer.sv @@
// ----------------------------------------------------------------------------
// gamepad_serial_host_sequencer
// Byte-level host sequencer for a serial gamepad: init script, poll frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one event per
//   transfer: a millisecond tick, a start-init or start-poll request, or the
//   reply byte for the last byte sent. Every input transfer yields exactly one
//   result transfer on the output channel (out_valid_o / out_stall_i /
//   out_data_o): nothing, a byte to send with select framing, a poll report,
//   or the init outcome.
//   The result is registered; throughput is one item per cycle while the
//   receiver does not stall, set by the single result register. The sequencer
//   state updates in the same edge that takes the item.
//   If the receiver stalls, the result register holds its payload and
//   in_stall_o rises only while that register is full and stalled; a result
//   taken in a cycle frees room for a new item in that same cycle.
//   cfg_we_i writes the 16-bit init timeout (in ticks) at once.
//   Reset leaves the sequencer idle, counters and ID cleared, timeout 5000,
//   output channel empty.
// ----------------------------------------------------------------------------
module gamepad_serial_host_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gshs_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gshs_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeInit = 2'd1;
  localparam logic [1:0] ModePoll = 2'd2;

  logic [1:0]  mode_q, mode_d;
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] timeout_q;
  logic [7:0]  reply_q [5];
  logic        reply_we;
  logic [2:0]  reply_idx;
  gshs_pkg::out_item_t res_d, out_q;
  logic        out_valid_q;
  logic        in_accept;

  // Handshake: take an item when the result register is free or draining
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Per-item sequencing
  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    id_d      = id_q;
    elapsed_d = elapsed_q;
    res_d     = '0;
    reply_we  = 1'b0;
    reply_idx = 3'(pos_q - gshs_pkg::PollFirstCap);
    unique case (in_data_i.action)
      gshs_pkg::ActTick: begin
        if (elapsed_q != 16'hFFFF) begin
          elapsed_d = elapsed_q + 16'd1;
        end
      end
      gshs_pkg::ActInit: begin
        elapsed_d = '0;
        id_d      = '0;
        pos_d     = '0;
        if (timeout_q == '0) begin
          mode_d     = ModeIdle;
          res_d.kind = gshs_pkg::KindDone;
        end else begin
          mode_d            = ModeInit;
          res_d.kind        = gshs_pkg::KindSend;
          res_d.tx_byte     = gshs_pkg::init_byte(5'd0);
          res_d.frame_first = 1'b1;
        end
      end
      gshs_pkg::ActPoll: begin
        mode_d            = ModePoll;
        pos_d             = '0;
        res_d.kind        = gshs_pkg::KindSend;
        res_d.tx_byte     = gshs_pkg::poll_byte(5'd0);
        res_d.frame_first = 1'b1;
      end
      default: begin
        unique case (mode_q)
          ModeInit: begin
            if (pos_q == gshs_pkg::IdPos) begin
              id_d = in_data_i.rx_byte;
            end
            if (pos_q == gshs_pkg::InitLastPos) begin
              priority if (id_q == gshs_pkg::AnalogId) begin
                mode_d        = ModeIdle;
                pos_d         = '0;
                res_d.kind    = gshs_pkg::KindDone;
                res_d.init_ok = 1'b1;
              end else if (elapsed_q < timeout_q) begin
                pos_d             = '0;
                res_d.kind        = gshs_pkg::KindSend;
                res_d.tx_byte     = gshs_pkg::init_byte(5'd0);
                res_d.frame_first = 1'b1;
              end else begin
                mode_d     = ModeIdle;
                pos_d      = '0;
                res_d.kind = gshs_pkg::KindDone;
              end
            end else begin
              pos_d             = pos_q + 5'd1;
              res_d.kind        = gshs_pkg::KindSend;
              res_d.tx_byte     = gshs_pkg::init_byte(pos_d);
              res_d.frame_first = gshs_pkg::init_first(pos_d);
              res_d.frame_last  = gshs_pkg::init_last(pos_d);
            end
          end
          ModePoll: begin
            if (pos_q >= gshs_pkg::PollLastPos) begin
              // last reply is the left stick Y axis, used directly
              mode_d        = ModeIdle;
              pos_d         = '0;
              res_d.kind    = gshs_pkg::KindReport;
              res_d.buttons = ~{reply_q[1], reply_q[0]};
              res_d.right_x = reply_q[2];
              res_d.right_y = reply_q[3];
              res_d.left_x  = reply_q[4];
              res_d.left_y  = in_data_i.rx_byte;
            end else begin
              reply_we          = (pos_q >= gshs_pkg::PollFirstCap);
              pos_d             = pos_q + 5'd1;
              res_d.kind        = gshs_pkg::KindSend;
              res_d.tx_byte     = gshs_pkg::poll_byte(pos_d);
              res_d.frame_last  = (pos_d == gshs_pkg::PollLastPos);
            end
          end
          default: begin
            // reply while idle is ignored
          end
        endcase
      end
    endcase
  end

  // Control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      pos_q       <= '0;
      id_q        <= '0;
      elapsed_q   <= '0;
      timeout_q   <= gshs_pkg::TimeoutReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        mode_q    <= mode_d;
        pos_q     <= pos_d;
        id_q      <= id_d;
        elapsed_q <= elapsed_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload and captured reply bytes
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= res_d;
      if (reply_we) begin
        reply_q[reply_idx] <= in_data_i.rx_byte;
      end
    end
  end

endmodule
